[hdl/bba_pkg.sv]
// Shared types, constants and helper functions for the bitmap block allocator.
`default_nettype none

package bba_pkg;

    // Fixed geometry of the used-block bitmap
    localparam int WORD_BITS       = 64;
    localparam int BIT_POS_W       = 6;
    localparam int FIELD_W         = 13;
    localparam int MAX_BLOCKS_DEF  = 4096;
    localparam int MAP_WORDS_DEF   = (MAX_BLOCKS_DEF + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_WORDS_DEF   = (MAP_WORDS_DEF + WORD_BITS - 1) / WORD_BITS;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_SUM   = 2'd2,
        ST_MAP   = 2'd3
    } state_t;

    // Input request payload
    typedef struct packed {
        kind_t                kind;
        logic [FIELD_W-1:0]   block_number;
    } in_req_t;

    // Result payload
    typedef struct packed {
        logic [FIELD_W-1:0]   handle;
        logic                 block_free;
        logic [FIELD_W-1:0]   used_count;
    } out_rsp_t;

    // Memory port controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } mem_ctl_t;

    // Lowest clear bit of a word
    typedef struct packed {
        logic                 found;
        logic [BIT_POS_W-1:0] pos;
    } zero_pos_t;

    // Status of the word held in a store's read register
    typedef struct packed {
        logic                 free_found;
        logic [BIT_POS_W-1:0] pos;
        logic                 bit_val;
        logic                 full_before;
        logic                 full_after;
    } word_stat_t;

    // Priority encoder: position of the lowest zero bit
    function automatic zero_pos_t first_zero(input logic [WORD_BITS-1:0] word);
        zero_pos_t res;
        res = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                res.found = 1'b1;
                res.pos   = BIT_POS_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/bitmap_block_allocator_core.sv]
// Top level of the bitmap block allocator: request sequencer, result register, config.
`default_nettype none

// First-fit block allocator over a used-block bitmap of 64-bit words held in a
// synchronous memory, with a second memory of "word full" bits and a small row
// of flip-flops marking full summary words, so an allocate finds the lowest free
// block with two memory reads. Each request (allocate, free, query) goes through
// a summary read, a bitmap read, then bitmap/summary write-back together with the
// result; the next request is taken in the cycle after write-back, even while
// the previous result is still waiting in the output register. Reset starts a
// clearing pass over all ceil(MAX_BLOCKS/64) bitmap words (64 at the default size)
// during which in_stall is high; configuration writes are taken at all times.
module bitmap_block_allocator_core #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bba_pkg::FIELD_W-1:0]   cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bba_pkg::in_req_t              in_data,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bba_pkg::out_rsp_t                  out_data
);

    localparam int WORDS     = (MAX_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int SUM_WORDS = (WORDS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int WIDX      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SIDX      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int PW        = bba_pkg::BIT_POS_W;
    localparam int WFULL     = SIDX + PW;
    localparam int IW        = WFULL + PW;
    localparam int FW        = bba_pkg::FIELD_W;

    // Control state
    bba_pkg::state_t    state_reg, state_next;
    logic [FW-1:0]      used_reg, used_next;
    logic               out_valid_reg, out_valid_next;
    logic [WIDX-1:0]    clr_reg, clr_next;
    logic [FW-1:0]      total_reg;

    // Per-request payload
    bba_pkg::kind_t     kind_reg, kind_next;
    logic [FW-1:0]      blk_reg, blk_next;
    logic               ok_reg, ok_next;
    logic               none_reg, none_next;
    logic [WFULL-1:0]   wsel_reg, wsel_next;
    bba_pkg::out_rsp_t  out_reg, out_next;

    // Store interfaces
    bba_pkg::mem_ctl_t   map_ctl, sum_ctl;
    logic [WIDX-1:0]     map_rd_addr, map_wr_addr;
    logic [SIDX-1:0]     sum_rd_addr, sum_wr_addr;
    bba_pkg::word_stat_t map_stat, sum_stat;
    logic [SIDX-1:0]     first_word;
    logic                all_full;

    // Working values
    logic [FW-1:0]      lim;
    logic [FW-1:0]      in_idx;
    logic               in_ok;
    logic [WFULL-1:0]   in_w;
    logic [FW-1:0]      blk_idx;
    logic [WFULL-1:0]   alloc_w;
    logic [IW-1:0]      alloc_idx;
    logic               is_alloc;
    logic               out_busy;
    logic [FW-1:0]      handle;
    logic               bfree;

    bba_map_store #(
        .WORDS (WORDS)
    ) u_map (
        .clk     (clk),
        .ctl     (map_ctl),
        .rd_addr (map_rd_addr),
        .wr_addr (map_wr_addr),
        .alloc   (is_alloc),
        .bit_sel (blk_idx[PW-1:0]),
        .stat    (map_stat)
    );

    bba_summary #(
        .SUM_WORDS (SUM_WORDS)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sum_ctl),
        .rd_addr    (sum_rd_addr),
        .wr_addr    (sum_wr_addr),
        .alloc      (is_alloc),
        .bit_sel    (wsel_reg[PW-1:0]),
        .stat       (sum_stat),
        .first_word (first_word),
        .all_full   (all_full)
    );

    // Effective total and request decode
    always_comb
    begin
        lim       = (32'(total_reg) > MAX_BLOCKS) ? FW'(MAX_BLOCKS) : total_reg;
        in_idx    = in_data.block_number - FW'(1);
        in_ok     = (in_data.block_number != '0) && (in_data.block_number <= lim);
        in_w      = WFULL'(in_idx[FW-1:PW]);
        blk_idx   = blk_reg - FW'(1);
        alloc_w   = {wsel_reg[WFULL-1:PW], sum_stat.pos};
        alloc_idx = {wsel_reg, map_stat.pos};
        is_alloc  = (kind_reg == bba_pkg::KIND_ALLOC);
        out_busy  = out_valid_reg && out_stall;
    end

    // Sequencer: next state, store controls and result
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && out_stall;
        clr_next       = clr_reg;
        kind_next      = kind_reg;
        blk_next       = blk_reg;
        ok_next        = ok_reg;
        none_next      = none_reg;
        wsel_next      = wsel_reg;
        out_next       = out_reg;
        map_ctl        = '0;
        sum_ctl        = '0;
        map_rd_addr    = wsel_reg[WIDX-1:0];
        map_wr_addr    = wsel_reg[WIDX-1:0];
        sum_rd_addr    = wsel_reg[WFULL-1:PW];
        sum_wr_addr    = wsel_reg[WFULL-1:PW];
        handle         = '0;
        bfree          = 1'b0;

        case (state_reg)
            // Post-reset sweep zeroing both memories
            bba_pkg::ST_CLEAR:
            begin
                map_ctl.wr_en = 1'b1;
                map_ctl.clear = 1'b1;
                map_wr_addr   = clr_reg;
                sum_ctl.wr_en = (32'(clr_reg) < SUM_WORDS);
                sum_ctl.clear = 1'b1;
                sum_wr_addr   = clr_reg[SIDX-1:0];
                clr_next      = clr_reg + WIDX'(1);
                if (clr_reg == WIDX'(WORDS - 1))
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end

            // Take a request and read its summary word
            bba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = in_data.kind;
                    blk_next      = in_data.block_number;
                    ok_next       = in_ok;
                    sum_ctl.rd_en = 1'b1;
                    if (in_data.kind == bba_pkg::KIND_ALLOC)
                    begin
                        wsel_next   = {first_word, PW'(0)};
                        none_next   = all_full;
                        sum_rd_addr = first_word;
                    end
                    else
                    begin
                        wsel_next   = in_w;
                        none_next   = 1'b0;
                        sum_rd_addr = in_w[WFULL-1:PW];
                    end
                    state_next = bba_pkg::ST_SUM;
                end
            end

            // Pick the bitmap word and read it
            bba_pkg::ST_SUM:
            begin
                if (is_alloc)
                begin
                    if (none_reg || !sum_stat.free_found || (32'(alloc_w) >= WORDS))
                    begin
                        none_next = 1'b1;
                    end
                    else
                    begin
                        wsel_next     = alloc_w;
                        map_ctl.rd_en = 1'b1;
                        map_rd_addr   = alloc_w[WIDX-1:0];
                    end
                end
                else
                begin
                    map_ctl.rd_en = ok_reg;
                end
                state_next = bba_pkg::ST_MAP;
            end

            // Write back and load the result register
            bba_pkg::ST_MAP:
            begin
                if (!out_busy)
                begin
                    case (kind_reg)
                        bba_pkg::KIND_ALLOC:
                        begin
                            if (!none_reg && map_stat.free_found && (alloc_idx < IW'(lim)))
                            begin
                                map_ctl.wr_en = 1'b1;
                                sum_ctl.wr_en = map_stat.full_after;
                                used_next     = used_reg + FW'(1);
                                handle        = FW'(alloc_idx + IW'(1));
                            end
                        end
                        bba_pkg::KIND_FREE:
                        begin
                            if (ok_reg && map_stat.bit_val)
                            begin
                                map_ctl.wr_en = 1'b1;
                                sum_ctl.wr_en = map_stat.full_before;
                                used_next     = used_reg - FW'(1);
                            end
                        end
                        bba_pkg::KIND_QUERY:
                        begin
                            bfree = ok_reg && !map_stat.bit_val;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.handle     = handle;
                    out_next.block_free = bfree;
                    out_next.used_count = used_next;
                    out_valid_next      = 1'b1;
                    state_next          = bba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::ST_CLEAR;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
            total_reg     <= FW'(4096);
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                total_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        blk_reg  <= blk_next;
        ok_reg   <= ok_next;
        none_reg <= none_next;
        wsel_reg <= wsel_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != bba_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // A result appears only out of the write-back state
    a_result_from_map: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bba_pkg::ST_MAP))
        else $error("result raised outside write-back");

    // Bitmap writes happen only while clearing or writing back
    a_map_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        map_ctl.wr_en |-> (state_reg == bba_pkg::ST_CLEAR || state_reg == bba_pkg::ST_MAP))
        else $error("bitmap write in wrong state");

    // A summary update on write-back always comes with a bitmap update
    a_sum_with_map: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_ctl.wr_en && state_reg == bba_pkg::ST_MAP) |-> map_ctl.wr_en)
        else $error("summary updated without bitmap write");

    // The used count moves only with a write-back to the bitmap
    a_count_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_reg) |-> $past(map_ctl.wr_en && state_reg == bba_pkg::ST_MAP))
        else $error("used count changed without bitmap write");
`endif

endmodule

`default_nettype wire

[hdl/bba_map_store.sv]
// Used-block bitmap memory with its read-modify-write bit update.
`default_nettype none

module bba_map_store #(
    parameter  int WORDS  = bba_pkg::MAP_WORDS_DEF,
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic                            clk,
    input  wire bba_pkg::mem_ctl_t               ctl,
    input  wire logic [ADDR_W-1:0]               rd_addr,
    input  wire logic [ADDR_W-1:0]               wr_addr,
    input  wire logic                            alloc,
    input  wire logic [bba_pkg::BIT_POS_W-1:0]   bit_sel,
    output bba_pkg::word_stat_t                  stat
);

    logic [bba_pkg::WORD_BITS-1:0] mem [WORDS];
    logic [bba_pkg::WORD_BITS-1:0] word_reg;

    bba_pkg::zero_pos_t             fz;
    logic [bba_pkg::BIT_POS_W-1:0]  pos;
    logic [bba_pkg::WORD_BITS-1:0]  mask;
    logic [bba_pkg::WORD_BITS-1:0]  new_word;
    logic [bba_pkg::WORD_BITS-1:0]  wr_word;

    // Bit selection and modify: allocate sets the lowest free bit, free clears one
    always_comb
    begin
        fz       = bba_pkg::first_zero(word_reg);
        pos      = alloc ? fz.pos : bit_sel;
        mask     = {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1} << pos;
        new_word = alloc ? (word_reg | mask) : (word_reg & ~mask);
        wr_word  = ctl.clear ? '0 : new_word;

        stat.free_found  = fz.found;
        stat.pos         = pos;
        stat.bit_val     = word_reg[pos];
        stat.full_before = &word_reg;
        stat.full_after  = &new_word;
    end

    // Synchronous memory with a registered read word
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (ctl.rd_en)
        begin
            word_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/bba_summary.sv]
// Full-word summary memory and its top-level full flags with the first-word encoder.
`default_nettype none

module bba_summary #(
    parameter  int SUM_WORDS = bba_pkg::SUM_WORDS_DEF,
    localparam int ADDR_W    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bba_pkg::mem_ctl_t               ctl,
    input  wire logic [ADDR_W-1:0]               rd_addr,
    input  wire logic [ADDR_W-1:0]               wr_addr,
    input  wire logic                            alloc,
    input  wire logic [bba_pkg::BIT_POS_W-1:0]   bit_sel,
    output bba_pkg::word_stat_t                  stat,
    output logic [ADDR_W-1:0]                    first_word,
    output logic                                 all_full
);

    logic [bba_pkg::WORD_BITS-1:0] mem [SUM_WORDS];
    logic [bba_pkg::WORD_BITS-1:0] word_reg;
    logic [SUM_WORDS-1:0]          top_reg;

    bba_pkg::zero_pos_t             fz;
    logic [bba_pkg::BIT_POS_W-1:0]  pos;
    logic [bba_pkg::WORD_BITS-1:0]  mask;
    logic [bba_pkg::WORD_BITS-1:0]  new_word;
    logic [bba_pkg::WORD_BITS-1:0]  wr_word;

    // Summary bit update: set when a map word fills, clear when it gains a free bit
    always_comb
    begin
        fz       = bba_pkg::first_zero(word_reg);
        pos      = alloc ? fz.pos : bit_sel;
        mask     = {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1} << pos;
        new_word = alloc ? (word_reg | mask) : (word_reg & ~mask);
        wr_word  = ctl.clear ? '0 : new_word;

        stat.free_found  = fz.found;
        stat.pos         = pos;
        stat.bit_val     = word_reg[pos];
        stat.full_before = &word_reg;
        stat.full_after  = &new_word;
    end

    // Lowest summary word that still names a non-full map word
    always_comb
    begin
        first_word = '0;
        for (int i = SUM_WORDS - 1; i >= 0; i--) begin
            if (!top_reg[i])
            begin
                first_word = ADDR_W'(i);
            end
        end
        all_full = &top_reg;
    end

    // Top flags: one per summary word, set when every word it covers is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            top_reg[wr_addr] <= ctl.clear ? 1'b0 : (&new_word);
        end
    end

    // Synchronous memory with a registered read word
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (ctl.rd_en)
        begin
            word_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[test/bitmap_block_allocator_core_checker.sv]
// Result checker for the bitmap block allocator: mirrors the block map and compares results.
module bitmap_block_allocator_core_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bba_pkg::FIELD_W-1:0]   cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  bba_pkg::in_req_t              in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  bba_pkg::out_rsp_t             out_data,
    output int                            mismatches,
    output int                            outstanding
);

    localparam int NWORDS = bba_pkg::MAP_WORDS_DEF;
    localparam int WBITS  = bba_pkg::WORD_BITS;
    localparam int CAP    = bba_pkg::MAX_BLOCKS_DEF;

    // Mirror of the used-block map, the running count and the total register
    logic [WBITS-1:0]              used_words [NWORDS];
    logic [bba_pkg::FIELD_W-1:0]   used_blocks;
    logic [bba_pkg::FIELD_W-1:0]   total_setting;

    bba_pkg::out_rsp_t             awaited_results [$];
    bba_pkg::out_rsp_t             want;
    int                            bad_count;

    // Totals above capacity saturate
    function automatic int block_limit();
        return (int'(total_setting) > CAP) ? CAP : int'(total_setting);
    endfunction

    // Apply one request to the mirrored map and return the result it should give
    function automatic bba_pkg::out_rsp_t apply_request(bba_pkg::in_req_t req);
        bba_pkg::out_rsp_t rsp;
        int                lim;
        int                idx;
        logic              hit;
        rsp = '0;
        lim = block_limit();
        idx = int'(req.block_number) - 1;
        case (req.kind)
            bba_pkg::KIND_ALLOC:
            begin
                // lowest clear bit of the first word that is not full
                hit = 1'b0;
                for (int w = 0; w < NWORDS && !hit; w++)
                begin
                    for (int b = 0; b < WBITS && !hit; b++)
                    begin
                        if (!used_words[w][b])
                        begin
                            hit = 1'b1;
                            if (w * WBITS + b < lim)
                            begin
                                used_words[w][b] = 1'b1;
                                used_blocks      = used_blocks + 1'b1;
                                rsp.handle       = bba_pkg::FIELD_W'(w * WBITS + b + 1);
                            end
                        end
                    end
                end
            end
            bba_pkg::KIND_FREE:
            begin
                if (req.block_number != 0 && int'(req.block_number) <= lim)
                begin
                    if (used_words[idx / WBITS][idx % WBITS])
                    begin
                        used_words[idx / WBITS][idx % WBITS] = 1'b0;
                        used_blocks = used_blocks - 1'b1;
                    end
                end
            end
            bba_pkg::KIND_QUERY:
            begin
                if (req.block_number != 0 && int'(req.block_number) <= lim)
                begin
                    rsp.block_free = !used_words[idx / WBITS][idx % WBITS];
                end
            end
            default:
            begin
                // unused kind: no change
            end
        endcase
        rsp.used_count = used_blocks;
        return rsp;
    endfunction

    // Watch the three channels on each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NWORDS; w++)
            begin
                used_words[w] = '0;
            end
            used_blocks   = '0;
            total_setting = bba_pkg::FIELD_W'(CAP);
            awaited_results.delete();
            bad_count     = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result side
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("result with none awaited: handle %0d free %0d used %0d",
                                 out_data.handle, out_data.block_free, out_data.used_count);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_data.handle !== want.handle ||
                        out_data.block_free !== want.block_free ||
                        out_data.used_count !== want.used_count)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("result mismatch: exp handle %0d free %0d used %0d, got handle %0d free %0d used %0d",
                                     want.handle, want.block_free, want.used_count,
                                     out_data.handle, out_data.block_free, out_data.used_count);
                    end
                end
            end
            // total register write
            if (cfg_valid && cfg_ready)
            begin
                total_setting = cfg_data;
            end
            // request side
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(apply_request(in_data));
            end
            mismatches  <= bad_count;
            outstanding <= awaited_results.size();
        end
    end

endmodule

[test/bitmap_block_allocator_core_tb.sv]
// Testbench top for the bitmap block allocator: clock, reset, stimulus and verdict.
module bitmap_block_allocator_core_tb;

    localparam int FW          = bba_pkg::FIELD_W;
    localparam int CAP         = bba_pkg::MAX_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 200000;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [FW-1:0]       cfg_data;
    logic                in_valid;
    logic                in_stall;
    bba_pkg::in_req_t    in_data;
    logic                out_valid;
    logic                out_stall;
    bba_pkg::out_rsp_t   out_data;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int send_idle_pct;
    int recv_stall_pct;
    int cur_limit;
    int est_used;

    bitmap_block_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    bitmap_block_allocator_core_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one request and hold it until taken
    task automatic send_request(bba_pkg::kind_t k, int blk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: k, block_number: FW'(blk)};
        if (k == bba_pkg::KIND_ALLOC)
            est_used++;
        else if (k == bba_pkg::KIND_FREE && est_used > 0 && blk != 0)
            est_used--;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the total register while the block is idle
    task automatic write_total(int value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= FW'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_limit = (value > CAP) ? CAP : value;
    endtask

    // Block number: mostly near the used region, sometimes anywhere
    function automatic int pick_block();
        int r;
        int span;
        r    = $urandom_range(99);
        span = est_used + 4;
        if (span > cur_limit + 1)
            span = cur_limit + 1;
        if (r < 8)
            return $urandom_range(8191);
        if (r < 12)
            return 0;
        if (r < 25)
            return $urandom_range(cur_limit + 1, 1);
        return $urandom_range(span, 1);
    endfunction

    // Random mix of requests
    task automatic random_requests(int count, int alloc_pct);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < alloc_pct)
                send_request(bba_pkg::KIND_ALLOC, $urandom_range(8191));
            else if (r < alloc_pct + (100 - alloc_pct) * 6 / 10)
                send_request(bba_pkg::KIND_FREE, pick_block());
            else if (r < 97)
                send_request(bba_pkg::KIND_QUERY, pick_block());
            else
                send_request(bba_pkg::KIND_NONE, $urandom_range(8191));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        send_idle_pct  = 32;
        recv_stall_pct = 63;
        cur_limit      = CAP;
        est_used       = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and every kind at full size
        send_request(bba_pkg::KIND_QUERY, 0);
        send_request(bba_pkg::KIND_QUERY, 1);
        send_request(bba_pkg::KIND_QUERY, CAP);
        send_request(bba_pkg::KIND_QUERY, 8191);
        send_request(bba_pkg::KIND_ALLOC, 0);
        send_request(bba_pkg::KIND_ALLOC, 8191);
        send_request(bba_pkg::KIND_QUERY, 1);
        send_request(bba_pkg::KIND_FREE, 0);
        send_request(bba_pkg::KIND_FREE, 8191);
        send_request(bba_pkg::KIND_FREE, 2);
        // freeing a block that is already free
        send_request(bba_pkg::KIND_FREE, 2);
        send_request(bba_pkg::KIND_NONE, 8191);
        send_request(bba_pkg::KIND_ALLOC, 0);

        // small total: allocation runs out, out-of-range block ignored
        write_total(3);
        send_request(bba_pkg::KIND_ALLOC, 0);
        send_request(bba_pkg::KIND_ALLOC, 0);
        send_request(bba_pkg::KIND_QUERY, 4);
        send_request(bba_pkg::KIND_FREE, 4);

        // total lowered below used blocks: they stay counted and cannot be freed
        write_total(1);
        send_request(bba_pkg::KIND_FREE, 2);
        send_request(bba_pkg::KIND_QUERY, 1);

        // total above capacity saturates
        write_total(8191);
        send_request(bba_pkg::KIND_QUERY, CAP);
        send_request(bba_pkg::KIND_FREE, 2);

        // zero total: nothing can be allocated
        write_total(0);
        send_request(bba_pkg::KIND_ALLOC, 0);
        send_request(bba_pkg::KIND_QUERY, 1);

        write_total(CAP);
        send_request(bba_pkg::KIND_FREE, 1);
        send_request(bba_pkg::KIND_FREE, 3);

        // Random phases, sender idling less than receiver
        write_total(130);
        random_requests(190, 55);
        write_total(64);
        random_requests(190, 50);

        // receiver idling less than sender
        send_idle_pct  = 63;
        recv_stall_pct = 32;
        write_total(8191);
        random_requests(200, 70);
        write_total(20);
        random_requests(190, 45);

        // no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_total($urandom_range(8191));
        random_requests(190, 50);
        write_total(CAP);
        random_requests(190, 60);

        drain_results();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[bitmap_block_allocator_core.f]
hdl/bba_pkg.sv
hdl/bba_map_store.sv
hdl/bba_summary.sv
hdl/bitmap_block_allocator_core.sv
test/bitmap_block_allocator_core_checker.sv
test/bitmap_block_allocator_core_tb.sv
